// ===== sv/tpdo_pkg.sv =====
// ----------------------------------------------------------------------------
// tpdo_pkg: shared types and constants of the transmit PDO scheduler
// Holds the channel count, register indexes, status codes and the records
// that pass between the front end, the work queue and the back end.
// ----------------------------------------------------------------------------
package tpdo_pkg;

   // Number of transmit channels that keep state (1 to 16).
   localparam int NUM_CHANNELS = 4;
   // Index width into the per-channel state.
   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Setup registers exist for four channels.
   localparam int NUM_SETUP = 4;

   // Work queue and result queue geometry; the depth is a power of two so
   // that the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Constants of the setup word.
   localparam logic [31:0] COB_DISABLE = 32'h8000_0000;
   localparam logic [10:0] COB_ID_MASK = 11'h7FF;
   localparam logic [3:0]  MAX_LEN     = 4'd8;

   // Configuration register indexes.
   localparam logic [2:0] CSR_OPERATIONAL = 3'd0;
   localparam logic [2:0] CSR_CH0_SETUP   = 3'd1;
   localparam logic [2:0] CSR_CH3_SETUP   = 3'd4;

   // Setup values after reset.
   localparam logic [63:0] SETUP_RESET [NUM_SETUP] = '{
      64'h0000_0181_0000_0064,
      64'h8000_0281_0000_0000,
      64'h8000_0381_0000_0000,
      64'h8000_0481_0000_0000
   };

   // Result codes.
   typedef enum logic [3:0] {
      ST_MARKED    = 4'd0,
      ST_STOPPED   = 4'd1,
      ST_DISABLED  = 4'd2,
      ST_NOT_DUE   = 4'd3,
      ST_INHIBITED = 4'd4,
      ST_PACK_FAIL = 4'd5,
      ST_UNCHANGED = 4'd6,
      ST_REFUSED   = 4'd7,
      ST_SENT      = 4'd8
   } status_type;

   // One classified item on its way from the front end to the back end.
   typedef struct packed {
      logic                op_mark;
      logic                ch_valid;
      logic [CH_IDX_W-1:0] ch_idx;
      logic                stopped;
      logic                disabled;
      logic [15:0]         hold_time;
      logic [15:0]         event_ms;
      logic [10:0]         can_id;
      logic [31:0]         now_ms;
      logic [63:0]         data;
      logic [3:0]          len;
      logic                pack_ok;
      logic                tx_accepted;
   } work_type;

   // One result item.
   typedef struct packed {
      status_type  status;
      logic        send;
      logic [10:0] can_id;
      logic [3:0]  dlc;
      logic [63:0] data;
   } rsp_type;

   // Head of the work queue as seen by the back end.
   typedef struct packed {
      logic     valid;
      work_type work;
   } head_type;

endpackage

// ===== sv/tpdo_transmit_scheduler.sv =====
// ----------------------------------------------------------------------------
// tpdo_transmit_scheduler: per-channel transmit PDO scheduler
// Front end classifies beats against the setup registers, a two-entry work
// queue decouples it from the back end, which decides per channel and
// queues one result for every accepted beat.
//
//   channel   direction  handshake          payload
//   req_      in         push / full        op, channel, now_ms, payload, ...
//   rsp_      out        empty / pop        status, send, can_id, dlc, data
//   csr_      in         csr_we             csr_index, csr_wdata
//
// One item per cycle is sustained while the result queue has room or is
// popped; the back end decides a work record combinationally and the
// channel state it writes is ready for the next one. A result reaches the
// rsp_ ports through the registered work queue and then the result queue.
// Reset is synchronous and clears all channel state at once;
// no clearing pass is needed. full rises when the work queue holds two
// records, which happens only while the result side is stalled.
// ----------------------------------------------------------------------------
module tpdo_transmit_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        push,
   output logic        full,
   input  logic        req_op,
   input  logic [1:0]  req_channel,
   input  logic [31:0] req_now_ms,
   input  logic [63:0] req_payload,
   input  logic [3:0]  req_payload_len,
   input  logic        req_pack_ok,
   input  logic        req_tx_accepted,
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_status,
   output logic        rsp_send,
   output logic [10:0] rsp_can_id,
   output logic [3:0]  rsp_dlc,
   output logic [63:0] rsp_data
);

   tpdo_pkg::work_type work;
   tpdo_pkg::head_type head;
   tpdo_pkg::rsp_type  rsp;
   logic               take;

   tpdo_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_op          (req_op),
      .req_channel     (req_channel),
      .req_now_ms      (req_now_ms),
      .req_payload     (req_payload),
      .req_payload_len (req_payload_len),
      .req_pack_ok     (req_pack_ok),
      .req_tx_accepted (req_tx_accepted),
      .work            (work)
   );

   tpdo_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .work_wr (work),
      .full    (full),
      .take    (take),
      .head    (head)
   );

   tpdo_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .take  (take),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign rsp_status = rsp.status;
   assign rsp_send   = rsp.send;
   assign rsp_can_id = rsp.can_id;
   assign rsp_dlc    = rsp.dlc;
   assign rsp_data   = rsp.data;

endmodule

// ===== sv/tpdo_front.sv =====
// ----------------------------------------------------------------------------
// tpdo_front: configuration registers and item classification
// Holds the operational flag and the channel setup words, and turns each
// incoming beat into a work record with the channel setup already decoded
// and the payload clamped and masked to its length.
// ----------------------------------------------------------------------------
module tpdo_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata,
   input  logic                req_op,
   input  logic [1:0]          req_channel,
   input  logic [31:0]         req_now_ms,
   input  logic [63:0]         req_payload,
   input  logic [3:0]          req_payload_len,
   input  logic                req_pack_ok,
   input  logic                req_tx_accepted,
   output tpdo_pkg::work_type  work
);

   logic        operational_ff;
   logic        operational_in;
   logic [63:0] setup_ff [tpdo_pkg::NUM_SETUP];
   logic [63:0] setup_in [tpdo_pkg::NUM_SETUP];

   logic [63:0] cfg;
   logic [31:0] cob;
   logic [3:0]  len_c;
   logic [63:0] mask;
   logic [3:0]  ch_ext;
   logic [2:0]  setup_sel;

   // Register writes; indexes beyond the list are dropped.
   always_comb begin
      operational_in = operational_ff;
      setup_in       = setup_ff;
      setup_sel      = csr_index - tpdo_pkg::CSR_CH0_SETUP;
      if (csr_we) begin
         if (csr_index == tpdo_pkg::CSR_OPERATIONAL) begin
            operational_in = csr_wdata[0];
         end else if (csr_index <= tpdo_pkg::CSR_CH3_SETUP) begin
            setup_in[setup_sel[1:0]] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         operational_ff <= 1'b1;
         setup_ff       <= tpdo_pkg::SETUP_RESET;
      end else begin
         operational_ff <= operational_in;
         setup_ff       <= setup_in;
      end
   end

   // Classification of the incoming beat.
   always_comb begin
      cfg    = setup_ff[req_channel];
      cob    = cfg[63:32];
      len_c  = (req_payload_len > tpdo_pkg::MAX_LEN) ? tpdo_pkg::MAX_LEN : req_payload_len;
      ch_ext = {2'b00, req_channel};
      for (int b = 0; b < 8; b++) begin
         mask[b*8 +: 8] = (4'(b) < len_c) ? 8'hFF : 8'h00;
      end

      work.op_mark     = req_op;
      work.ch_valid    = {3'b000, req_channel} < 5'(tpdo_pkg::NUM_CHANNELS);
      work.ch_idx      = ch_ext[tpdo_pkg::CH_IDX_W-1:0];
      work.stopped     = !operational_ff;
      work.disabled    = (cob & tpdo_pkg::COB_DISABLE) != 32'd0;
      work.hold_time   = cfg[31:16];
      work.event_ms    = cfg[15:0];
      work.can_id      = cob[10:0] & tpdo_pkg::COB_ID_MASK;
      work.now_ms      = req_now_ms;
      work.data        = req_payload & mask;
      work.len         = len_c;
      work.pack_ok     = req_pack_ok;
      work.tx_accepted = req_tx_accepted;
   end

endmodule

// ===== sv/tpdo_queue.sv =====
// ----------------------------------------------------------------------------
// tpdo_queue: short work queue between front end and back end
// Two-entry FIFO of classified work records so that either side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module tpdo_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpdo_pkg::work_type  work_wr,
   output logic                full,
   input  logic                take,
   output tpdo_pkg::head_type  head
);

   tpdo_pkg::work_type             mem_ff [tpdo_pkg::QUEUE_DEPTH];
   logic [tpdo_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [tpdo_pkg::QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [tpdo_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [tpdo_pkg::QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [tpdo_pkg::QUEUE_CNT_W-1:0] count_ff;
   logic [tpdo_pkg::QUEUE_CNT_W-1:0] count_in;
   logic                             do_push;
   logic                             do_take;

   // Pointer and fill bookkeeping.
   always_comb begin
      do_push   = push && (count_ff != tpdo_pkg::QUEUE_CNT_W'(tpdo_pkg::QUEUE_DEPTH));
      do_take   = take && (count_ff != '0);
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + tpdo_pkg::QUEUE_CNT_W'(do_push)
                           - tpdo_pkg::QUEUE_CNT_W'(do_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= work_wr;
      end
   end

   assign full       = (count_ff == tpdo_pkg::QUEUE_CNT_W'(tpdo_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.work  = mem_ff[rd_ptr_ff];

endmodule

// ===== sv/tpdo_back.sv =====
// ----------------------------------------------------------------------------
// tpdo_back: per-channel scheduling decision and result queue
// Takes one record per cycle while results can be queued, checks timers,
// inhibit and change against the channel state, updates it, queues result.
// ----------------------------------------------------------------------------
module tpdo_back (
   input  logic                clock,
   input  logic                reset,
   input  tpdo_pkg::head_type  head,
   output logic                take,
   output logic                empty,
   input  logic                pop,
   output tpdo_pkg::rsp_type   rsp
);

   // Channel state.
   logic [31:0] last_time_ff    [tpdo_pkg::NUM_CHANNELS];
   logic [31:0] last_time_in    [tpdo_pkg::NUM_CHANNELS];
   logic [63:0] last_data_ff    [tpdo_pkg::NUM_CHANNELS];
   logic [63:0] last_data_in    [tpdo_pkg::NUM_CHANNELS];
   logic [3:0]  last_len_ff     [tpdo_pkg::NUM_CHANNELS];
   logic [3:0]  last_len_in     [tpdo_pkg::NUM_CHANNELS];
   logic        last_known_ff   [tpdo_pkg::NUM_CHANNELS];
   logic        last_known_in   [tpdo_pkg::NUM_CHANNELS];
   logic        pending_ff      [tpdo_pkg::NUM_CHANNELS];
   logic        pending_in      [tpdo_pkg::NUM_CHANNELS];

   // Result queue.
   tpdo_pkg::rsp_type                res_mem_ff [tpdo_pkg::QUEUE_DEPTH];
   logic [tpdo_pkg::QUEUE_PTR_W-1:0] res_wr_ff;
   logic [tpdo_pkg::QUEUE_PTR_W-1:0] res_wr_in;
   logic [tpdo_pkg::QUEUE_PTR_W-1:0] res_rd_ff;
   logic [tpdo_pkg::QUEUE_PTR_W-1:0] res_rd_in;
   logic [tpdo_pkg::QUEUE_CNT_W-1:0] res_cnt_ff;
   logic [tpdo_pkg::QUEUE_CNT_W-1:0] res_cnt_in;

   tpdo_pkg::work_type wk;
   tpdo_pkg::rsp_type  res;
   logic               step;
   logic               res_pop;
   logic [31:0]        elapsed;
   logic               due;
   logic               same;

   assign wk = head.work;

   // Decision for the record at the queue head.
   always_comb begin
      step    = head.valid && ((res_cnt_ff != tpdo_pkg::QUEUE_CNT_W'(tpdo_pkg::QUEUE_DEPTH))
                               || pop);
      res_pop = pop && (res_cnt_ff != '0);

      last_time_in  = last_time_ff;
      last_data_in  = last_data_ff;
      last_len_in   = last_len_ff;
      last_known_in = last_known_ff;
      pending_in    = pending_ff;

      elapsed = wk.now_ms - last_time_ff[wk.ch_idx];
      due     = pending_ff[wk.ch_idx] ||
                ((wk.event_ms != 16'd0) && (elapsed >= {16'd0, wk.event_ms}));
      same    = last_known_ff[wk.ch_idx] && (last_len_ff[wk.ch_idx] == wk.len) &&
                (last_data_ff[wk.ch_idx] == wk.data);

      res.status = tpdo_pkg::ST_MARKED;
      res.send   = 1'b0;
      res.can_id = '0;
      res.dlc    = '0;
      res.data   = '0;

      priority if (wk.op_mark) begin
         res.status = tpdo_pkg::ST_MARKED;
         if (step && wk.ch_valid) begin
            pending_in[wk.ch_idx] = 1'b1;
         end
      end else if (wk.stopped) begin
         res.status = tpdo_pkg::ST_STOPPED;
      end else if (!wk.ch_valid || wk.disabled) begin
         res.status = tpdo_pkg::ST_DISABLED;
      end else if (!due) begin
         res.status = tpdo_pkg::ST_NOT_DUE;
      end else if ((wk.hold_time != 16'd0) && (elapsed < {16'd0, wk.hold_time})) begin
         res.status = tpdo_pkg::ST_INHIBITED;
      end else if (!wk.pack_ok) begin
         res.status = tpdo_pkg::ST_PACK_FAIL;
      end else if (same) begin
         res.status = tpdo_pkg::ST_UNCHANGED;
         if (step) begin
            pending_in[wk.ch_idx] = 1'b0;
         end
      end else begin
         res.send   = 1'b1;
         res.can_id = wk.can_id;
         res.dlc    = wk.len;
         res.data   = wk.data;
         if (wk.tx_accepted) begin
            res.status = tpdo_pkg::ST_SENT;
            if (step) begin
               last_time_in[wk.ch_idx]  = wk.now_ms;
               last_data_in[wk.ch_idx]  = wk.data;
               last_len_in[wk.ch_idx]   = wk.len;
               last_known_in[wk.ch_idx] = 1'b1;
               pending_in[wk.ch_idx]    = 1'b0;
            end
         end else begin
            res.status = tpdo_pkg::ST_REFUSED;
         end
      end

      res_wr_in  = step ? res_wr_ff + 1'b1 : res_wr_ff;
      res_rd_in  = res_pop ? res_rd_ff + 1'b1 : res_rd_ff;
      res_cnt_in = res_cnt_ff + tpdo_pkg::QUEUE_CNT_W'(step)
                              - tpdo_pkg::QUEUE_CNT_W'(res_pop);
   end

   // State and queue control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tpdo_pkg::NUM_CHANNELS; i++) begin
            last_time_ff[i]  <= '0;
            last_data_ff[i]  <= '0;
            last_len_ff[i]   <= '0;
            last_known_ff[i] <= 1'b0;
            pending_ff[i]    <= 1'b0;
         end
         res_wr_ff  <= '0;
         res_rd_ff  <= '0;
         res_cnt_ff <= '0;
      end else begin
         last_time_ff  <= last_time_in;
         last_data_ff  <= last_data_in;
         last_len_ff   <= last_len_in;
         last_known_ff <= last_known_in;
         pending_ff    <= pending_in;
         res_wr_ff     <= res_wr_in;
         res_rd_ff     <= res_rd_in;
         res_cnt_ff    <= res_cnt_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (step) begin
         res_mem_ff[res_wr_ff] <= res;
      end
   end

   assign take  = step;
   assign empty = (res_cnt_ff == '0);
   assign rsp   = res_mem_ff[res_rd_ff];

   // The result queue never holds more than its depth.
   a_res_depth: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= tpdo_pkg::QUEUE_CNT_W'(tpdo_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   // A frame goes out only with a refused or sent status.
   a_send_status: assert property (@(posedge clock) disable iff (reset)
      (step && res.send) |-> (res.status == tpdo_pkg::ST_REFUSED ||
                              res.status == tpdo_pkg::ST_SENT))
      else $error("send flag without a frame status");

   // An accepted frame leaves its channel without a pending request.
   a_sent_clears: assert property (@(posedge clock) disable iff (reset)
      (step && res.status == tpdo_pkg::ST_SENT) |=> !pending_ff[$past(wk.ch_idx)])
      else $error("pending flag survived a sent frame");

   // A result is written only while a record is at the queue head.
   a_step_head: assert property (@(posedge clock) disable iff (reset)
      (res_cnt_ff == '0 && !head.valid) |=> (res_cnt_ff == '0))
      else $error("result without a work record");

endmodule
